>>> hw/rtl/svcp_pkg.sv
`timescale 1ns / 1ps

package svcp_pkg;

  localparam int unsigned LineBufferBytesDefault = 32;

  localparam int unsigned CharW = 8;
  localparam int unsigned VolW  = 7;

  localparam logic [CharW-1:0] CharCr    = 8'h0D;
  localparam logic [CharW-1:0] CharLf    = 8'h0A;
  localparam logic [CharW-1:0] CharNul   = 8'h00;
  localparam logic [CharW-1:0] CharSpace = 8'h20;
  localparam logic [CharW-1:0] CharZero  = 8'h30;
  localparam logic [CharW-1:0] CharNine  = 8'h39;
  localparam logic [CharW-1:0] CharP     = 8'h50;
  localparam logic [CharW-1:0] CharI     = 8'h49;
  localparam logic [CharW-1:0] CharN     = 8'h4E;
  localparam logic [CharW-1:0] CharG     = 8'h47;
  localparam logic [CharW-1:0] CharV     = 8'h56;
  localparam logic [CharW-1:0] CharO     = 8'h4F;
  localparam logic [CharW-1:0] CharL     = 8'h4C;

  localparam logic [VolW-1:0] VolMax = 7'd100;

  typedef enum logic [1:0] {
    KIND_NONE = 2'd0,
    KIND_PING = 2'd1,
    KIND_VOL  = 2'd2
  } svcp_kind_e;

  // Matcher position, one-hot
  typedef enum logic [10:0] {
    PH_START   = 11'b000_0000_0001,
    PH_P       = 11'b000_0000_0010,
    PH_PI      = 11'b000_0000_0100,
    PH_PIN     = 11'b000_0000_1000,
    PH_PING    = 11'b000_0001_0000,
    PH_V       = 11'b000_0010_0000,
    PH_VO      = 11'b000_0100_0000,
    PH_VOL     = 11'b000_1000_0000,
    PH_DIGITS  = 11'b001_0000_0000,
    PH_FAIL    = 11'b010_0000_0000,
    PH_VOLDONE = 11'b100_0000_0000
  } svcp_phase_e;

  typedef struct packed {
    logic             valid;
    logic [CharW-1:0] char_byte;
  } svcp_item_t;

  typedef struct packed {
    svcp_kind_e      command_kind;
    logic [VolW-1:0] volume_percent;
  } svcp_result_t;

endpackage

>>> hw/rtl/serial_volume_command_parser.sv
`timescale 1ns / 1ps
// Path: an accepted request is loaded into the input register; its result
//   enters the result register once that register can take it, and is offered
//   from there on the result side.
// Throughput: one request per cycle while the result side does not stall, one
//   result per request; the line matcher state advances with each parsed byte.
// Reset (rst_ni low, asynchronous): both register stages empty, line state at
//   line start with length, volume and text-end flag cleared.
module serial_volume_command_parser #(
  parameter int unsigned LINE_BUFFER_BYTES = svcp_pkg::LineBufferBytesDefault
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  // Request side
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] char_byte
  // Result side
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [6:0] volume_percent, [7] zero
  output logic [1:0] m_axis_tuser    // [1:0] command_kind
);
  import svcp_pkg::*;

  svcp_item_t   item;
  svcp_result_t step_res;
  svcp_result_t out_res;
  logic         out_ready;
  logic         adv;

  // A held byte is parsed when the result register can take its result;
  // the line state moves in the same cycle.
  assign adv = item.valid && out_ready;

  svcp_in_reg u_in_reg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .s_data_i  (s_axis_tdata),
    .adv_i     (adv),
    .item_o    (item)
  );

  // Character matcher: PING / VOL<spaces><digits>, saturating at 100
  svcp_step #(
    .LINE_BUFFER_BYTES (LINE_BUFFER_BYTES)
  ) u_step (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .adv_i    (adv),
    .char_i   (item.char_byte),
    .result_o (step_res)
  );

  // Result register; frees itself in the cycle the result is taken
  svcp_out_reg u_out_reg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .adv_i     (adv),
    .result_i  (step_res),
    .ready_o   (out_ready),
    .m_valid_o (m_axis_tvalid),
    .m_ready_i (m_axis_tready),
    .result_o  (out_res)
  );

  assign m_axis_tdata = {1'b0, out_res.volume_percent};
  assign m_axis_tuser = out_res.command_kind;

endmodule

>>> hw/rtl/svcp_in_reg.sv
`timescale 1ns / 1ps

module svcp_in_reg (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_valid_i,
  output logic                           s_ready_o,
  input  logic [svcp_pkg::CharW-1:0]     s_data_i,
  input  logic                           adv_i,
  output svcp_pkg::svcp_item_t           item_o
);
  import svcp_pkg::*;

  logic             valid_q, valid_d;
  logic [CharW-1:0] char_q;

  // Free slot, or the held byte leaves this cycle
  assign s_ready_o = !valid_q || adv_i;
  assign valid_d   = s_ready_o ? s_valid_i : valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_valid_i && s_ready_o) begin
      char_q <= s_data_i;
    end
  end

  assign item_o.valid     = valid_q;
  assign item_o.char_byte = char_q;

endmodule

>>> hw/rtl/svcp_step.sv
`timescale 1ns / 1ps

module svcp_step #(
  parameter int unsigned LINE_BUFFER_BYTES = svcp_pkg::LineBufferBytesDefault
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       adv_i,
  input  logic [svcp_pkg::CharW-1:0] char_i,
  output svcp_pkg::svcp_result_t     result_o
);
  import svcp_pkg::*;

  localparam int unsigned LenW = $clog2(LINE_BUFFER_BYTES);
  localparam logic [LenW-1:0] LenLast = LenW'(LINE_BUFFER_BYTES - 1);

  logic [LenW-1:0] len_q, len_d;
  svcp_phase_e     phase_q, phase_d, phase_nx;
  logic [VolW-1:0] acc_q, acc_d, acc_nx;
  logic            ended_q, ended_d;

  logic            is_term, is_digit;
  logic [3:0]      digit;
  logic [10:0]     acc_x10;
  logic [VolW-1:0] acc_sat;

  assign is_term  = (char_i == CharCr) || (char_i == CharLf);
  assign is_digit = (char_i >= CharZero) && (char_i <= CharNine);
  assign digit    = char_i[3:0];
  assign acc_x10  = ({4'd0, acc_q} << 3) + ({4'd0, acc_q} << 1) + {7'd0, digit};
  assign acc_sat  = (acc_x10 > {4'd0, VolMax}) ? VolMax : acc_x10[VolW-1:0];

  // Matcher transition for a non-terminator, non-NUL character
  always_comb begin
    phase_nx = PH_FAIL;
    acc_nx   = acc_q;
    unique case (phase_q)
      PH_START: begin
        if (char_i == CharP) begin
          phase_nx = PH_P;
        end else if (char_i == CharV) begin
          phase_nx = PH_V;
        end
      end
      PH_P:   phase_nx = (char_i == CharI) ? PH_PI  : PH_FAIL;
      PH_PI:  phase_nx = (char_i == CharN) ? PH_PIN : PH_FAIL;
      PH_PIN: phase_nx = (char_i == CharG) ? PH_PING : PH_FAIL;
      PH_V:   phase_nx = (char_i == CharO) ? PH_VO  : PH_FAIL;
      PH_VO:  phase_nx = (char_i == CharL) ? PH_VOL : PH_FAIL;
      PH_VOL: begin
        if (char_i == CharSpace) begin
          phase_nx = PH_VOL;
        end else if (is_digit) begin
          phase_nx = PH_DIGITS;
          acc_nx   = {3'd0, digit};
        end
      end
      PH_DIGITS: begin
        if (is_digit) begin
          phase_nx = PH_DIGITS;
          acc_nx   = acc_sat;
        end else begin
          phase_nx = PH_VOLDONE;
        end
      end
      PH_VOLDONE: phase_nx = PH_VOLDONE;
      default:    phase_nx = PH_FAIL;
    endcase
  end

  always_comb begin
    result_o.command_kind   = KIND_NONE;
    result_o.volume_percent = '0;
    len_d   = len_q;
    phase_d = phase_q;
    acc_d   = acc_q;
    ended_d = ended_q;
    if (is_term) begin
      if (len_q != '0) begin
        if (phase_q == PH_PING) begin
          result_o.command_kind = KIND_PING;
        end else if (phase_q == PH_DIGITS || phase_q == PH_VOLDONE) begin
          result_o.command_kind   = KIND_VOL;
          result_o.volume_percent = acc_q;
        end
      end
      len_d   = '0;
      phase_d = PH_START;
      acc_d   = '0;
      ended_d = 1'b0;
    end else if (len_q != LenLast) begin
      len_d = len_q + 1'b1;
      if (!ended_q) begin
        if (char_i == CharNul) begin
          ended_d = 1'b1;
        end else begin
          phase_d = phase_nx;
          acc_d   = acc_nx;
        end
      end
    end else begin
      // overlong line: drop it and start over
      len_d   = '0;
      phase_d = PH_START;
      acc_d   = '0;
      ended_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q   <= '0;
      phase_q <= PH_START;
      acc_q   <= '0;
      ended_q <= 1'b0;
    end else if (adv_i) begin
      len_q   <= len_d;
      phase_q <= phase_d;
      acc_q   <= acc_d;
      ended_q <= ended_d;
    end
  end

  a_vol_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc_q <= VolMax)
    else $error("volume accumulator above saturation limit");

  a_len_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    len_q <= LenLast)
    else $error("line length beyond buffer");

  a_clear_after_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv_i && result_o.command_kind != KIND_NONE)
      |=> (phase_q == PH_START && len_q == '0 && !ended_q))
    else $error("line state not cleared after command");

  a_ended_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ended_q |-> (len_q != '0))
    else $error("text end flag set on empty line");

endmodule

>>> hw/rtl/svcp_out_reg.sv
`timescale 1ns / 1ps

module svcp_out_reg (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   adv_i,
  input  svcp_pkg::svcp_result_t result_i,
  output logic                   ready_o,
  output logic                   m_valid_o,
  input  logic                   m_ready_i,
  output svcp_pkg::svcp_result_t result_o
);
  import svcp_pkg::*;

  logic         valid_q, valid_d;
  svcp_result_t result_q;

  assign ready_o = !valid_q || m_ready_i;
  assign valid_d = adv_i ? 1'b1 : (m_ready_i ? 1'b0 : valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      result_q <= result_i;
    end
  end

  assign m_valid_o = valid_q;
  assign result_o  = result_q;

endmodule
